// ===== rtl/vn_pkg.sv =====
// Shared types and constants for the vector normalizer.
// No dependencies; every other file refers to it by scoped names.
package vn_pkg;

	localparam int unsigned LANES       = 3;
	localparam int unsigned COMP_W      = 32;
	localparam int unsigned SQ_W        = 63;
	localparam int unsigned LEN_W       = 64;
	localparam int unsigned THR_W       = 32;
	localparam int unsigned QUOT_W      = 63;
	localparam int unsigned ROOT_W      = 32;
	localparam int unsigned UNIT_W      = 32;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [THR_W-1:0] THR_RESET = 32'd43;

	// One classified vector, handed from the front to the back.
	typedef struct packed {
		logic [LANES-1:0][SQ_W-1:0] sq;
		logic [LANES-1:0]           neg;
		logic [LEN_W-1:0]           len2;
		logic                       degen;
	} vn_item_t;

endpackage

// ===== rtl/vn_front.sv =====
// Front end: takes magnitudes, squares and the squared length, then
// classifies against the threshold. Depends on vn_pkg.
module vn_front (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic [vn_pkg::LANES-1:0][vn_pkg::COMP_W-1:0] in_comp,
	input  logic [vn_pkg::THR_W-1:0]                   thr,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output vn_pkg::vn_item_t                           out_item
);

	logic                                          adv;
	logic                                          v_s1, v_s2, v_s3;
	logic [vn_pkg::LANES-1:0][vn_pkg::COMP_W-1:0]  mag_s1;
	logic [vn_pkg::LANES-1:0]                      neg_s1, neg_s2, neg_s3;
	logic [vn_pkg::LANES-1:0][vn_pkg::SQ_W-1:0]    sq_s2, sq_s3;
	logic [vn_pkg::LEN_W-1:0]                      len2_s3;
	logic [vn_pkg::LANES-1:0][2*vn_pkg::COMP_W-1:0] prod;

	// Advance the whole front while its last stage is empty or drains.
	assign adv      = !v_s3 || out_ready;
	assign in_ready = adv;

	always_comb begin
		for (int i = 0; i < vn_pkg::LANES; i++) begin
			prod[i] = 64'(mag_s1[i]) * 64'(mag_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < vn_pkg::LANES; i++) begin
				neg_s1[i] <= in_comp[i][vn_pkg::COMP_W-1];
				mag_s1[i] <= in_comp[i][vn_pkg::COMP_W-1] ? (~in_comp[i] + 1'b1) : in_comp[i];
				sq_s2[i]  <= prod[i][vn_pkg::SQ_W-1:0];
			end
			neg_s2  <= neg_s1;
			neg_s3  <= neg_s2;
			sq_s3   <= sq_s2;
			len2_s3 <= 64'(sq_s2[0]) + 64'(sq_s2[1]) + 64'(sq_s2[2]);
		end
	end

	assign out_valid      = v_s3;
	assign out_item.sq    = sq_s3;
	assign out_item.neg   = neg_s3;
	assign out_item.len2  = len2_s3;
	assign out_item.degen = (len2_s3 <= 64'(thr));

endmodule

// ===== rtl/vn_queue.sv =====
// Short queue between the front and the back end.
// Depends on vn_pkg for the item type.
module vn_queue #(
	parameter int unsigned DEPTH = vn_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  vn_pkg::vn_item_t push_item,
	output logic             pop_valid,
	input  logic             pop_ready,
	output vn_pkg::vn_item_t pop_item
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	vn_pkg::vn_item_t   mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/vn_back.sv =====
// Back end: pipelined restoring divide of mag^2 * 2^62 by the squared length,
// pipelined integer square root, rounding and sign. Depends on vn_pkg.
module vn_back (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  vn_pkg::vn_item_t                           in_item,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic [vn_pkg::LANES-1:0][vn_pkg::UNIT_W-1:0] out_unit,
	output logic                                       out_degen
);

	localparam int unsigned DSTEPS = vn_pkg::QUOT_W;
	localparam int unsigned RSTEPS = vn_pkg::ROOT_W;
	localparam int unsigned RAD_W  = 2 * vn_pkg::ROOT_W;
	localparam int unsigned REM_W  = vn_pkg::ROOT_W + 2;

	logic adv;

	// Divider stages, index 0 is the load stage.
	logic                        dv   [DSTEPS+1];
	logic [vn_pkg::LEN_W-1:0]    dlen [DSTEPS+1];
	logic [vn_pkg::LANES-1:0]    dneg [DSTEPS+1];
	logic                        ddeg [DSTEPS+1];
	logic [vn_pkg::LEN_W-1:0]    drem [vn_pkg::LANES][DSTEPS+1];
	logic [vn_pkg::QUOT_W-1:0]   dquo [vn_pkg::LANES][DSTEPS+1];
	logic                        dlow [vn_pkg::LANES];

	// Root stages, index 1..RSTEPS.
	logic                        rv   [RSTEPS+1];
	logic [vn_pkg::LANES-1:0]    rneg [RSTEPS+1];
	logic                        rdeg [RSTEPS+1];
	logic [RAD_W-1:0]            rrad [vn_pkg::LANES][RSTEPS+1];
	logic [REM_W-1:0]            rrem [vn_pkg::LANES][RSTEPS+1];
	logic [vn_pkg::ROOT_W-1:0]   rroot[vn_pkg::LANES][RSTEPS+1];

	logic                                        out_valid_q;
	logic                                        out_degen_q;
	logic [vn_pkg::LANES-1:0][vn_pkg::UNIT_W-1:0] out_unit_q;

	// Move the whole back end together whenever the output slot frees up.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (adv) begin
			dv[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dlen[0] <= in_item.len2;
			dneg[0] <= in_item.neg;
			ddeg[0] <= in_item.degen;
		end
	end

	for (genvar l = 0; l < vn_pkg::LANES; l++) begin : g_load
		always_ff @(posedge clk) begin
			if (adv) begin
				drem[l][0] <= {2'b00, in_item.sq[l][vn_pkg::SQ_W-1:1]};
				dquo[l][0] <= '0;
				dlow[l]    <= in_item.sq[l][0];
			end
		end
	end

	for (genvar j = 0; j < DSTEPS; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv[j+1] <= 1'b0;
			end else if (adv) begin
				dv[j+1] <= dv[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dlen[j+1] <= dlen[j];
				dneg[j+1] <= dneg[j];
				ddeg[j+1] <= ddeg[j];
			end
		end
		for (genvar l = 0; l < vn_pkg::LANES; l++) begin : g_lane
			logic                       bit_in;
			logic [vn_pkg::LEN_W:0]     trial;
			logic [vn_pkg::LEN_W:0]     diff;
			logic                       ge;
			// Only the first step brings in a nonzero dividend bit.
			assign bit_in = (j == 0) ? dlow[l] : 1'b0;
			assign trial  = {drem[l][j], bit_in};
			assign diff   = trial - {1'b0, dlen[j]};
			assign ge     = (trial >= {1'b0, dlen[j]});
			always_ff @(posedge clk) begin
				if (adv) begin
					drem[l][j+1] <= ge ? diff[vn_pkg::LEN_W-1:0] : trial[vn_pkg::LEN_W-1:0];
					dquo[l][j+1] <= {dquo[l][j][vn_pkg::QUOT_W-2:0], ge};
				end
			end
		end
	end

	for (genvar k = 0; k < RSTEPS; k++) begin : g_root
		logic                     src_v;
		logic [vn_pkg::LANES-1:0] src_neg;
		logic                     src_deg;
		if (k == 0) begin : g_first
			assign src_v   = dv[DSTEPS];
			assign src_neg = dneg[DSTEPS];
			assign src_deg = ddeg[DSTEPS];
		end else begin : g_next
			assign src_v   = rv[k];
			assign src_neg = rneg[k];
			assign src_deg = rdeg[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv[k+1] <= 1'b0;
			end else if (adv) begin
				rv[k+1] <= src_v;
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				rneg[k+1] <= src_neg;
				rdeg[k+1] <= src_deg;
			end
		end
		for (genvar l = 0; l < vn_pkg::LANES; l++) begin : g_lane
			logic [RAD_W-1:0]          src_rad;
			logic [REM_W-1:0]          src_rem;
			logic [vn_pkg::ROOT_W-1:0] src_root;
			logic [REM_W+1:0]          cur;
			logic [REM_W+1:0]          trial;
			logic [REM_W+1:0]          diff;
			logic                      ge;
			if (k == 0) begin : g_first
				assign src_rad  = {1'b0, dquo[l][DSTEPS]};
				assign src_rem  = '0;
				assign src_root = '0;
			end else begin : g_next
				assign src_rad  = rrad[l][k];
				assign src_rem  = rrem[l][k];
				assign src_root = rroot[l][k];
			end
			assign cur   = {src_rem, src_rad[RAD_W-1 -: 2]};
			assign trial = {2'b00, src_root, 2'b01};
			assign diff  = cur - trial;
			assign ge    = (cur >= trial);
			always_ff @(posedge clk) begin
				if (adv) begin
					rrad[l][k+1]  <= {src_rad[RAD_W-3:0], 2'b00};
					rrem[l][k+1]  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
					rroot[l][k+1] <= {src_root[vn_pkg::ROOT_W-2:0], ge};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= rv[RSTEPS];
		end
	end

	for (genvar l = 0; l < vn_pkg::LANES; l++) begin : g_out
		logic [vn_pkg::ROOT_W:0]   nsum;
		logic [vn_pkg::UNIT_W-1:0] mag;
		// Largest n with 2n-1 <= root, i.e. round half up.
		assign nsum = {1'b0, rroot[l][RSTEPS]} + 1'b1;
		assign mag  = nsum[vn_pkg::ROOT_W:1];
		always_ff @(posedge clk) begin
			if (adv) begin
				out_unit_q[l] <= rdeg[RSTEPS] ? '0 : (rneg[RSTEPS][l] ? (~mag + 1'b1) : mag);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_degen_q <= rdeg[RSTEPS];
		end
	end

	assign out_valid = out_valid_q;
	assign out_unit  = out_unit_q;
	assign out_degen = out_degen_q;

endmodule

// ===== rtl/vector3_normalise_top.sv =====
// Top level of the three-component vector normalizer.
// Depends on vn_pkg, vn_front, vn_queue and vn_back.
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    s_tdata: in_x, in_y, in_z (Q16.16)
// m_*       out        m_tvalid/m_tready    m_tdata: unit_x/y/z (Q1.30), m_tuser: degenerate
// cfg_*     in         cfg_valid/cfg_ready  cfg_data: min_length_squared
//
// Throughput is one vector per cycle while neither the queue nor the output stalls.
// The pipeline has 3 front stages, the queue, and 1 + 63 + 32 + 1 back stages. The back end
// is a 63-step restoring divider followed by a 32-step square-root pipeline.
// Reset clears all valid flags and loads the threshold with 43.
// A stalled output freezes the back end; the front keeps filling the queue
// until it is full, then deasserts s_tready.
module vector3_normalise_top #(
	parameter int unsigned QUEUE_DEPTH = vn_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // [31:0] in_x, [63:32] in_y, [95:64] in_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,   // [31:0] unit_x, [63:32] unit_y, [95:64] unit_z
	output logic [0:0]  m_tuser,   // [0] degenerate
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data   // min_length_squared
);

	logic [vn_pkg::THR_W-1:0]                      thr_q;
	logic [vn_pkg::LANES-1:0][vn_pkg::COMP_W-1:0]  in_comp;
	logic [vn_pkg::LANES-1:0][vn_pkg::UNIT_W-1:0]  out_unit;
	logic                                          f_valid, q_ready;
	logic                                          b_valid, b_ready;
	vn_pkg::vn_item_t                              f_item, b_item;

	// Threshold register; the user must write it only while the block is idle, the block itself does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= vn_pkg::THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// Unpack the input components, x in the lowest bits.
	assign in_comp[0] = s_tdata[31:0];
	assign in_comp[1] = s_tdata[63:32];
	assign in_comp[2] = s_tdata[95:64];

	vn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_comp   (in_comp),
		.thr       (thr_q),
		.out_valid (f_valid),
		.out_ready (q_ready),
		.out_item  (f_item)
	);

	// Decouple the classify side from the long arithmetic side.
	vn_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (q_ready),
		.push_item  (f_item),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_item   (b_item)
	);

	vn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (b_valid),
		.in_ready  (b_ready),
		.in_item   (b_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_unit  (out_unit),
		.out_degen (m_tuser[0])
	);

	assign m_tdata = {out_unit[2], out_unit[1], out_unit[0]};

	// A degenerate result carries a zero vector.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 96'd0)
		else $error("degenerate transaction with nonzero components");

	// Every component lies within plus or minus one in Q1.30.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
		($signed(m_tdata[31:0])  <= 32'sd1073741824 &&
		 $signed(m_tdata[31:0])  >= -32'sd1073741824 &&
		 $signed(m_tdata[63:32]) <= 32'sd1073741824 &&
		 $signed(m_tdata[63:32]) >= -32'sd1073741824 &&
		 $signed(m_tdata[95:64]) <= 32'sd1073741824 &&
		 $signed(m_tdata[95:64]) >= -32'sd1073741824))
		else $error("normalized component out of range");

	// Back-pressure at the input only comes from a full queue.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> f_valid && !q_ready)
		else $error("input stalled without a full queue");

endmodule
